// ===== rtl/bdre_pkg.sv =====
package bdre_pkg;

  localparam logic [7:0]  FLAG_DELTA_BLOCK = 8'd1;
  localparam logic [15:0] COUNT_LIMIT      = 16'hFFFF;

  // One three-byte record: a run triple, or the block header with the
  // flag byte in value and the block length in count.
  typedef struct packed {
    logic [7:0]  value;
    logic [15:0] count;
    logic        eob;
  } rec_t;

  // The records caused by one request, in output order.
  typedef struct packed {
    rec_t a;
    logic has_b;
    rec_t b;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  typedef enum logic [2:0] {
    POS_VALUE = 3'b001,
    POS_LOW   = 3'b010,
    POS_HIGH  = 3'b100
  } pos_t;

endpackage

// ===== rtl/bdre_stream_if.sv =====
interface bdre_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  old_byte;
  logic [7:0]  new_byte;
  logic        first_item;
  logic        last_item;
  logic [15:0] block_length;

  modport source (output valid, old_byte, new_byte, first_item, last_item, block_length,
                  input ready);
  modport sink (input valid, old_byte, new_byte, first_item, last_item, block_length,
                output ready);
endinterface

interface bdre_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_block;

  modport source (output valid, out_byte, end_of_block, input ready);
  modport sink (input valid, out_byte, end_of_block, output ready);
endinterface

// ===== rtl/bdre_front.sv =====
module bdre_front
  import bdre_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  bdre_in_if.sink  in_item,
  input  logic     full,
  output push_t    push
);

  logic [7:0]  run_value, run_value_next;
  logic [15:0] run_count, run_count_next;
  logic        in_block, in_block_next;
  logic [7:0]  diff;
  logic        accept;
  logic        has_a;
  logic        has_b;
  rec_t        rec_a;
  rec_t        rec_b;
  rec_t        rec_final;

  assign in_item.ready = !full;
  assign accept = in_item.valid && !full;
  assign diff = in_item.old_byte - in_item.new_byte;

  always_comb begin
    run_value_next = run_value;
    run_count_next = run_count;
    in_block_next  = in_block;
    has_a = 1'b0;
    has_b = 1'b0;
    rec_a = '0;
    rec_b = '0;
    rec_final = '0;
    if (in_item.first_item) begin
      has_a = 1'b1;
      rec_a = '{value: FLAG_DELTA_BLOCK, count: in_item.block_length, eob: 1'b0};
      run_value_next = diff;
      run_count_next = 16'd1;
      in_block_next  = 1'b1;
    end else if (in_block) begin
      if (diff == run_value && run_count != COUNT_LIMIT) begin
        run_count_next = run_count + 16'd1;
      end else begin
        has_a = 1'b1;
        rec_a = '{value: run_value, count: run_count, eob: 1'b0};
        run_value_next = diff;
        run_count_next = 16'd1;
      end
    end
    if (in_item.last_item && (in_item.first_item || in_block)) begin
      rec_final = '{value: run_value_next, count: run_count_next, eob: 1'b1};
      if (has_a) begin
        has_b = 1'b1;
        rec_b = rec_final;
      end else begin
        has_a = 1'b1;
        rec_a = rec_final;
      end
      run_value_next = 8'd0;
      run_count_next = 16'd0;
      in_block_next  = 1'b0;
    end
  end

  assign push.valid       = accept && has_a;
  assign push.entry.a     = rec_a;
  assign push.entry.has_b = has_b;
  assign push.entry.b     = rec_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_value <= 8'd0;
      run_count <= 16'd0;
      in_block  <= 1'b0;
    end else if (accept) begin
      run_value <= run_value_next;
      run_count <= run_count_next;
      in_block  <= in_block_next;
    end
  end

endmodule

// ===== rtl/bdre_queue.sv =====
module bdre_queue
  import bdre_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  push_t  push,
  output logic   full,
  output logic   not_empty,
  output entry_t head,
  input  logic   pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;

  assign full      = (fill == CNT_W'(DEPTH));
  assign not_empty = (fill != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push.valid && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push.valid) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/bdre_back.sv =====
module bdre_back
  import bdre_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      not_empty,
  input  entry_t    head,
  output logic      pop,
  bdre_out_if.source out_item
);

  logic   busy;
  entry_t cur;
  logic   sel_b;
  pos_t   pos;
  rec_t   rec;
  logic   fire;
  logic   done;

  assign rec  = sel_b ? cur.b : cur.a;
  assign fire = busy && out_item.ready;
  assign done = fire && pos == POS_HIGH && (sel_b || !cur.has_b);
  assign pop  = not_empty && (!busy || done);

  assign out_item.valid = busy;

  always_comb begin
    unique case (pos)
      POS_VALUE: out_item.out_byte = rec.value;
      POS_LOW:   out_item.out_byte = rec.count[7:0];
      POS_HIGH:  out_item.out_byte = rec.count[15:8];
      default:   out_item.out_byte = rec.value;
    endcase
  end

  assign out_item.end_of_block = rec.eob && pos == POS_HIGH;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      sel_b <= 1'b0;
      pos   <= POS_VALUE;
    end else if (pop) begin
      busy  <= 1'b1;
      sel_b <= 1'b0;
      pos   <= POS_VALUE;
    end else if (done) begin
      busy  <= 1'b0;
    end else if (fire) begin
      unique case (pos)
        POS_VALUE: pos <= POS_LOW;
        POS_LOW:   pos <= POS_HIGH;
        POS_HIGH: begin
          pos   <= POS_VALUE;
          sel_b <= 1'b1;
        end
        default:   pos <= POS_VALUE;
      endcase
    end
  end

endmodule

// ===== rtl/byte_delta_rle_encoder_unit.sv =====
// Channel   Role    Fields
// in_item   sink    old_byte[8], new_byte[8], first_item, last_item, block_length[16]
// out_item  source  out_byte[8], end_of_block
//
// Requests are accepted while the group queue has room; the output emits one
// byte per cycle unless stalled, so each header or run triple is sent as three bytes.
// A request that closes a run and ends the block, or opens and ends it, gives six bytes.
// Reset is synchronous and clears the run state, the queue and the output stage.
// A stalled output holds its byte; up to QUEUE_DEPTH groups of records buffer input.
module byte_delta_rle_encoder_unit
  import bdre_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  bdre_in_if.sink    in_item,
  bdre_out_if.source out_item
);

  push_t  push;
  logic   full;
  logic   not_empty;
  entry_t head;
  logic   pop;

  bdre_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_item (in_item),
    .full    (full),
    .push    (push)
  );

  bdre_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop)
  );

  bdre_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/bdre_checker.sv =====
module bdre_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       end_of_block
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(end_of_block))
    else $error("output payload changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_full_busy: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input blocked while output is idle");

endmodule

bind byte_delta_rle_encoder_unit bdre_checker u_bdre_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_item.ready),
  .out_valid    (out_item.valid),
  .out_ready    (out_item.ready),
  .out_byte     (out_item.out_byte),
  .end_of_block (out_item.end_of_block)
);

// ===== tb/sv/bdre_encode_check.sv =====
module bdre_encode_check
  import bdre_pkg::*;
(
  input  logic clk,
  input  logic rst,
  bdre_in_if   in_item,
  bdre_out_if  out_item,
  output int   mismatches,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       eob;
  } enc_byte_t;

  enc_byte_t   expected_bytes[$];
  logic [7:0]  open_value;
  logic [15:0] open_count;
  logic        block_open;

  task automatic push_byte(input logic [7:0] data, input logic eob);
    enc_byte_t entry;
    entry.data = data;
    entry.eob  = eob;
    expected_bytes.insert(expected_bytes.size(), entry);
  endtask

  task automatic push_run(input logic eob);
    push_byte(open_value, 1'b0);
    push_byte(open_count[7:0], 1'b0);
    push_byte(open_count[15:8], eob);
  endtask

  task automatic encode_pair(input logic [7:0] old_b, input logic [7:0] new_b,
                             input logic first, input logic last,
                             input logic [15:0] len);
    logic [7:0] diff;
    diff = old_b - new_b;
    if (first) begin
      push_byte(FLAG_DELTA_BLOCK, 1'b0);
      push_byte(len[7:0], 1'b0);
      push_byte(len[15:8], 1'b0);
      open_value = diff;
      open_count = 16'd1;
      block_open = 1'b1;
    end else if (!block_open) begin
      return;
    end else if (diff == open_value && open_count < COUNT_LIMIT) begin
      open_count = open_count + 16'd1;
    end else begin
      push_run(1'b0);
      open_value = diff;
      open_count = 16'd1;
    end
    if (last) begin
      push_run(1'b1);
      open_value = 8'd0;
      open_count = 16'd0;
      block_open = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    enc_byte_t want;
    if (rst) begin
      open_value = 8'd0;
      open_count = 16'd0;
      block_open = 1'b0;
      expected_bytes.delete();
      mismatches = 0;
    end else begin
      if (out_item.valid && out_item.ready) begin
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected byte %02h eob %0b", $time, out_item.out_byte,
                     out_item.end_of_block);
        end else begin
          want = expected_bytes.pop_front();
          if (want.data !== out_item.out_byte || want.eob !== out_item.end_of_block) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected byte %02h eob %0b, got byte %02h eob %0b", $time,
                       want.data, want.eob, out_item.out_byte, out_item.end_of_block);
          end
        end
      end
      if (in_item.valid && in_item.ready)
        encode_pair(in_item.old_byte, in_item.new_byte, in_item.first_item,
                    in_item.last_item, in_item.block_length);
    end
    pending = expected_bytes.size();
  end

endmodule

// ===== tb/sv/tb_byte_delta_rle_encoder_unit.sv =====
module tb_byte_delta_rle_encoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;
  int   mismatches;
  int   pending;
  bit   in_steady;
  bit   out_steady;
  bit   block_open;
  int   random_items;

  bdre_in_if  in_item();
  bdre_out_if out_item();

  byte_delta_rle_encoder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .out_item (out_item)
  );

  bdre_encode_check encode_check (
    .clk        (clk),
    .rst        (rst),
    .in_item    (in_item),
    .out_item   (out_item),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic send_pair(input logic [7:0] old_b, input logic [7:0] new_b,
                           input logic first, input logic last,
                           input logic [15:0] len);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_item.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item.valid        <= 1'b1;
    in_item.old_byte     <= old_b;
    in_item.new_byte     <= new_b;
    in_item.first_item   <= first;
    in_item.last_item    <= last;
    in_item.block_length <= len;
    do @(posedge clk); while (!in_item.ready);
    @(negedge clk);
  endtask

  task automatic send_block(input int n, input bit close);
    logic [7:0]  diff;
    logic [7:0]  old_b;
    logic [15:0] len;
    diff = 8'($urandom);
    len = $urandom_range(0, 1) ? 16'(n) : 16'($urandom);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 1))
        diff = 8'($urandom);
      old_b = 8'($urandom);
      send_pair(old_b, old_b - diff, i == 0, close && i == n - 1, len);
    end
    block_open = !close;
  endtask

  initial begin
    int stall;
    out_item.ready = 1'b0;
    out_steady = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = out_steady ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_item.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_item.ready <= 1'b1;
      do @(posedge clk); while (!(out_item.valid && out_item.ready));
      @(negedge clk);
      if ($urandom_range(0, 15) == 0)
        out_steady = !out_steady;
    end
  end

  initial begin
    int n;
    int pick;
    rst = 1'b1;
    in_item.valid = 1'b0;
    in_item.old_byte = 8'd0;
    in_item.new_byte = 8'd0;
    in_item.first_item = 1'b0;
    in_item.last_item = 1'b0;
    in_item.block_length = 16'd0;
    in_steady = 1'b0;
    block_open = 1'b0;
    random_items = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Requests outside a block must be dropped silently.
    send_pair(8'hFF, 8'hFF, 1'b0, 1'b1, 16'hFFFF);
    send_pair(8'h00, 8'h00, 1'b0, 1'b0, 16'h0000);
    send_pair(8'hFF, 8'h00, 1'b1, 1'b1, 16'hFFFF);
    send_pair(8'h00, 8'hFF, 1'b1, 1'b1, 16'h0000);
    send_pair(8'h00, 8'h01, 1'b1, 1'b0, 16'h0004);
    send_pair(8'h10, 8'h11, 1'b0, 1'b0, 16'h0000);
    send_pair(8'h80, 8'h7F, 1'b0, 1'b0, 16'h0000);
    send_pair(8'h7F, 8'h80, 1'b0, 1'b1, 16'h0000);
    // A new first request abandons the open block.
    send_pair(8'h55, 8'hAA, 1'b1, 1'b0, 16'h1234);
    send_pair(8'h55, 8'hAA, 1'b0, 1'b0, 16'h0000);
    send_pair(8'hAA, 8'h55, 1'b1, 1'b0, 16'h00A5);
    send_pair(8'hAA, 8'h55, 1'b0, 1'b0, 16'hFFFF);
    send_pair(8'h00, 8'h00, 1'b0, 1'b1, 16'h0000);
    send_pair(8'h12, 8'h34, 1'b0, 1'b0, 16'h5A5A);
    send_pair(8'h01, 8'h01, 1'b1, 1'b0, 16'h0001);
    send_pair(8'h02, 8'h02, 1'b0, 1'b0, 16'h0000);
    send_pair(8'h03, 8'h03, 1'b0, 1'b1, 16'h0000);

    while (random_items < 220) begin
      pick = $urandom_range(0, 9);
      if (pick == 0 && !block_open) begin
        send_pair(8'($urandom), 8'($urandom), 1'b0, 1'($urandom), 16'($urandom));
      end else begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 6);
        send_block(n, pick != 1);
        random_items += n;
      end
      if ($urandom_range(0, 15) == 0)
        in_steady = !in_steady;
    end
    in_item.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
